@@ sv/tach_pkg.sv @@
`timescale 1ns / 1ps
package tach_pkg;

  localparam int SUM_W      = 37;
  localparam int PERIOD_W   = 32;
  localparam int CAP_W      = 16;
  localparam int RPM_W      = 20;
  localparam int DIV_CNT_W  = 6;

  // averaging divides by PERIOD_COUNT (at most 32) one hex digit per step
  localparam int AVG_DIGIT_W = 4;
  localparam int AVG_REM_W   = 5;
  localparam int AVG_DIGITS  = (SUM_W + AVG_DIGIT_W - 1) / AVG_DIGIT_W;

  localparam logic [RPM_W-1:0]     RPM_MAX        = '1;
  localparam logic [PERIOD_W-1:0]  RPM_CONST_RST  = 32'd1000000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEP_LAST  = DIV_CNT_W'(SUM_W - 1);
  localparam logic [DIV_CNT_W-1:0] AVG_STEP_LAST  = DIV_CNT_W'(AVG_DIGITS - 1);

  typedef enum logic [1:0] {
    CMD_OVERFLOW = 2'd0,
    CMD_CAPTURE  = 2'd1,
    CMD_RESTART  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [CAP_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] average_period;
    logic [RPM_W-1:0]    rpm;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } q_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_AVG,
    B_RPM,
    B_DONE
  } back_state_t;

endpackage

@@ sv/tach_front.sv @@
`timescale 1ns / 1ps
module tach_front #(
  parameter int PERIOD_COUNT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tach_pkg::in_item_t in_data,
  input  logic               q_full,
  output tach_pkg::q_entry_t push
);
  import tach_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_COUNT + 1);

  logic [CAP_W-1:0] ovf_r, ovf_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             meas_r, meas_nxt;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // extended period: overflow ticks form the upper half
  assign sum_add  = sum_r + SUM_W'({ovf_r, in_data.capture_value});

  always_comb begin
    ovf_nxt    = ovf_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    meas_nxt   = meas_r;
    push.valid = 1'b0;
    push.sum   = sum_add;
    if (accept) begin
      case (in_data.command)
        CMD_OVERFLOW: begin
          if (ovf_r != '1) ovf_nxt = ovf_r + 1'b1;
        end
        CMD_RESTART: begin
          meas_nxt = 1'b1;
          sum_nxt  = '0;
          cnt_nxt  = '0;
        end
        CMD_CAPTURE: begin
          ovf_nxt = '0;
          if (meas_r) begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == CNT_W'(PERIOD_COUNT - 1)) begin
              // last period: hand the sum to the back end and go idle
              push.valid = 1'b1;
              meas_nxt   = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      meas_r <= 1'b0;
    end else begin
      ovf_r  <= ovf_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      meas_r <= meas_nxt;
    end
  end

endmodule

@@ sv/tach_queue.sv @@
`timescale 1ns / 1ps
module tach_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tach_pkg::q_entry_t push,
  input  logic               pop,
  output tach_pkg::q_entry_t head,
  output logic               full
);
  import tach_pkg::*;

  logic [SUM_W-1:0] data_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.sum   = data_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) data_r[wr_ptr_r] <= push.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ sv/tach_back.sv @@
`timescale 1ns / 1ps
module tach_back #(
  parameter int PERIOD_COUNT = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tach_pkg::q_entry_t               head,
  output logic                             pop,
  input  logic [tach_pkg::PERIOD_W-1:0]    rpm_constant,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tach_pkg::out_item_t              out_data
);
  import tach_pkg::*;

  localparam int WIN_W     = AVG_REM_W + AVG_DIGIT_W;
  localparam int AVG_DVD_W = AVG_DIGITS * AVG_DIGIT_W;

  back_state_t          state_r, state_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt, rem_step;
  logic [SUM_W-1:0]     dvd_r, dvd_nxt, dvd_step;
  logic [PERIOD_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PERIOD_W-1:0]  avg_r, avg_nxt, avg_step;
  logic [RPM_W-1:0]     rpm_r, rpm_nxt;
  logic [AVG_DVD_W-1:0] adv_r, adv_nxt;
  logic [WIN_W-1:0]     win, win_rem;
  logic [AVG_DIGIT_W-1:0] digit;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [PERIOD_W:0]    sh, diff;
  logic                 ge;

  // one restoring step: remainder and quotient share the dividend shifter
  assign sh       = {rem_r, dvd_r[SUM_W-1]};
  assign diff     = sh - {1'b0, dsr_r};
  assign ge       = (sh >= {1'b0, dsr_r});
  assign rem_step = ge ? diff[PERIOD_W-1:0] : sh[PERIOD_W-1:0];
  assign dvd_step = {dvd_r[SUM_W-2:0], ge};

  // radix-16 step of sum / PERIOD_COUNT: take the largest multiple that fits
  assign win      = {rem_r[AVG_REM_W-1:0], adv_r[AVG_DVD_W-1 -: AVG_DIGIT_W]};
  assign avg_step = {avg_r[PERIOD_W-AVG_DIGIT_W-1:0], digit};

  always_comb begin
    digit   = '0;
    win_rem = win;
    for (int j = 1; j < (1 << AVG_DIGIT_W); j++) begin
      if (win >= WIN_W'(PERIOD_COUNT * j)) begin
        digit   = AVG_DIGIT_W'(j);
        win_rem = win - WIN_W'(PERIOD_COUNT * j);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dsr_nxt       = dsr_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    rpm_nxt       = rpm_r;
    adv_nxt       = adv_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          rem_nxt   = '0;
          adv_nxt   = AVG_DVD_W'(head.sum);
          cnt_nxt   = AVG_STEP_LAST;
          state_nxt = B_AVG;
        end
      end
      B_AVG: begin
        rem_nxt = PERIOD_W'(win_rem);
        adv_nxt = {adv_r[AVG_DVD_W-AVG_DIGIT_W-1:0], {AVG_DIGIT_W{1'b0}}};
        avg_nxt = avg_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rem_nxt   = '0;
          dvd_nxt   = SUM_W'(rpm_constant);
          dsr_nxt   = avg_step;
          cnt_nxt   = DIV_STEP_LAST;
          state_nxt = B_RPM;
        end
      end
      B_RPM: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // a zero average yields an all-ones quotient, which saturates too
          rpm_nxt   = (dvd_step[SUM_W-1:RPM_W] != '0) ? RPM_MAX : dvd_step[RPM_W-1:0];
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.average_period = avg_r;
          out_data_nxt.rpm            = rpm_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    dsr_r      <= dsr_nxt;
    cnt_r      <= cnt_nxt;
    avg_r      <= avg_nxt;
    rpm_r      <= rpm_nxt;
    adv_r      <= adv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ sv/tachometer_period_average_rpm_core.sv @@
// A request is taken whenever in_ready is high; in_ready drops only while two finished
// measurements wait in the front/back queue.
// After the capture that completes a measurement, the back end runs ten radix-16
// steps of sum / PERIOD_COUNT, then a 37-step restoring division of rpm_constant / average.
// The back end takes a new measurement only after its last result has left B_DONE.
// Synchronous active-low reset clears state, queue and output; rpm_constant goes to 1000000.
`timescale 1ns / 1ps
module tachometer_period_average_rpm_core #(
  parameter int PERIOD_COUNT = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tach_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tach_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tach_pkg::PERIOD_W-1:0] cfg_data
);
  import tach_pkg::*;

  logic [PERIOD_W-1:0] rpm_const_r;
  q_entry_t            push, head;
  logic                q_full, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_const_r <= RPM_CONST_RST;
    end else if (cfg_valid && cfg_ready) begin
      rpm_const_r <= cfg_data;
    end
  end

  tach_front #(.PERIOD_COUNT(PERIOD_COUNT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  tach_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  tach_back #(.PERIOD_COUNT(PERIOD_COUNT)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .rpm_constant (rpm_const_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

@@ sv/tach_checker.sv @@
`timescale 1ns / 1ps
module tach_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input tach_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input tach_pkg::out_item_t           out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [tach_pkg::PERIOD_W-1:0] cfg_data
);
  import tach_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // zero average must saturate the speed
  a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.average_period == '0 |-> out_data.rpm == RPM_MAX)
    else $error("zero average without saturated rpm");

  // the register takes every write at once
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind tachometer_period_average_rpm_core tach_checker u_chk (.*);

@@ dv/tachometer_period_average_rpm_core_tb.sv @@
`timescale 1ns / 1ps
module tachometer_period_average_rpm_core_tb;
  import tach_pkg::*;

  localparam int AVG_WINDOW      = 20;
  localparam int RESULT_LATENCY  = 100;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int OVF_RUN         = 120;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data  = '0;

  // predictor state
  logic [CAP_W-1:0]    ovf_ticks;
  logic [SUM_W-1:0]    period_acc;
  logic [4:0]          periods_taken;
  logic                window_open;
  logic [PERIOD_W-1:0] rpm_scale;
  out_item_t           expected_readings[$];

  out_item_t           want;
  int                  faults        = 0;
  int                  requests_sent = 0;
  int                  quiet_cycles  = 0;
  int                  stall_left    = 0;
  bit                  idle_in       = 1'b0;
  bit                  idle_out      = 1'b0;

  tachometer_period_average_rpm_core #(
    .PERIOD_COUNT(AVG_WINDOW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: while idle_out is set, random stall bursts, each followed by out_ready again; else always ready.
  always @(posedge clk) begin
    if (!rst_n || !idle_out) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!out_ready || $urandom_range(0, 9) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("reading with none pending: average_period %0d, rpm %0d",
               out_data.average_period, out_data.rpm);
        faults++;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.average_period !== want.average_period) begin
          $error("average_period: expected %0d, actual %0d",
                 want.average_period, out_data.average_period);
          faults++;
        end
        if (out_data.rpm !== want.rpm) begin
          $error("rpm: expected %0d, actual %0d", want.rpm, out_data.rpm);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tachometer_period_average_rpm_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic predict_reading(input in_item_t req);
    logic [PERIOD_W-1:0] span;
    logic [PERIOD_W-1:0] mean;
    logic [PERIOD_W-1:0] quotient;
    out_item_t           rd;
    case (req.command)
      CMD_OVERFLOW: begin
        if (ovf_ticks != '1) ovf_ticks = ovf_ticks + 1'b1;
      end
      CMD_RESTART: begin
        window_open   = 1'b1;
        period_acc    = '0;
        periods_taken = '0;
      end
      CMD_CAPTURE: begin
        span      = {ovf_ticks, req.capture_value};
        ovf_ticks = '0;
        if (window_open) begin
          period_acc    = period_acc + SUM_W'(span);
          periods_taken = periods_taken + 5'd1;
          if (periods_taken >= AVG_WINDOW) begin
            mean = PERIOD_W'(period_acc / SUM_W'(AVG_WINDOW));
            rd.average_period = mean;
            if (mean == 0) begin
              rd.rpm = RPM_MAX;
            end else begin
              quotient = rpm_scale / mean;
              rd.rpm = (quotient > PERIOD_W'(RPM_MAX)) ? RPM_MAX : quotient[RPM_W-1:0];
            end
            expected_readings.push_back(rd);
            window_open = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] command, input logic [CAP_W-1:0] capture);
    in_item_t req;
    req.command       = command;
    req.capture_value = capture;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_reading(req);
    if (command != CMD_UNUSED) requests_sent++;
    if (idle_in && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Hold off new requests until every pending reading is out, then let the divider settle.
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_rpm_constant(input logic [PERIOD_W-1:0] value);
    drain_readings();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rpm_scale = value;
  endtask

  function automatic logic [PERIOD_W-1:0] random_rpm_constant();
    logic [PERIOD_W-1:0] value;
    if ($urandom_range(0, 1) == 0) value = $urandom_range(1, 32'h00FF_FFFF);
    else value = $urandom();
    if (value == 0) value = 1;
    return value;
  endfunction

  task automatic drive_measurement(input int tick_max, input int cap_hi);
    int pick;
    send_request(CMD_RESTART, CAP_W'($urandom()));
    for (int i = 0; i < AVG_WINDOW; i++) begin
      repeat ($urandom_range(0, tick_max)) send_request(CMD_OVERFLOW, CAP_W'($urandom()));
      pick = $urandom_range(0, 99);
      if (pick < 3) send_request(CMD_RESTART, CAP_W'($urandom()));
      else if (pick < 8) send_request(CMD_UNUSED, CAP_W'($urandom()));
      send_request(CMD_CAPTURE, CAP_W'($urandom_range(0, cap_hi)));
    end
  endtask

  task automatic run_measurements(input int count, input int tick_max, input int cap_hi,
                                  input bit idling);
    int start;
    start = requests_sent;
    while (requests_sent - start < count) begin
      idle_in  = idling && ($urandom_range(0, 3) != 0);
      idle_out = idling && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) begin
        drive_measurement(tick_max, cap_hi);
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(2'($urandom_range(0, 3)), CAP_W'($urandom()));
      end
    end
  endtask

  task automatic test_directed_edges();
    idle_in  = 1'b0;
    idle_out = 1'b1;
    send_request(CMD_OVERFLOW, 16'h0000);
    send_request(CMD_CAPTURE, 16'hABCD);  // idle: clears ticks, no reading
    send_request(CMD_UNUSED, 16'hFFFF);
    send_request(CMD_RESTART, 16'h0000);
    send_request(CMD_OVERFLOW, 16'hFFFF);
    send_request(CMD_OVERFLOW, 16'h5555);
    send_request(CMD_CAPTURE, 16'hFFFF);
    send_request(CMD_OVERFLOW, 16'h0000);
    send_request(CMD_RESTART, 16'hFFFF);  // restart mid-window keeps the tick
    for (int i = 0; i < AVG_WINDOW; i++) begin
      case (i % 3)
        0:       send_request(CMD_CAPTURE, 16'hFFFF);
        1:       send_request(CMD_CAPTURE, 16'h0000);
        default: send_request(CMD_CAPTURE, 16'h8001);
      endcase
    end
    send_request(CMD_CAPTURE, 16'h1234);
  endtask

  task automatic test_long_overflow_run();
    drain_readings();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_request(CMD_RESTART, 16'h0000);
    repeat (OVF_RUN) send_request(CMD_OVERFLOW, CAP_W'($urandom()));
    send_request(CMD_CAPTURE, 16'hFFFF);
    for (int i = 1; i < AVG_WINDOW; i++) send_request(CMD_CAPTURE, CAP_W'($urandom()));
  endtask

  task automatic test_rpm_constant_min();
    write_rpm_constant(32'd1);
    run_measurements(150, 1, 16'hFFFF, 1'b1);
  endtask

  task automatic test_rpm_constant_max();
    write_rpm_constant('1);
    run_measurements(150, 0, 255, 1'b1);
    run_measurements(150, 2, 16'hFFFF, 1'b1);
  endtask

  task automatic test_zero_average();
    write_rpm_constant(random_rpm_constant());
    run_measurements(200, 0, 1, 1'b1);
  endtask

  task automatic test_random_constants();
    repeat (4) begin
      write_rpm_constant(random_rpm_constant());
      run_measurements(200, 3, 16'hFFFF, 1'b1);
    end
  endtask

  task automatic test_steady_stream();
    write_rpm_constant(RPM_CONST_RST);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    run_measurements(250, 2, 16'hFFFF, 1'b0);
  endtask

  initial begin
    ovf_ticks     = '0;
    period_acc    = '0;
    periods_taken = '0;
    window_open   = 1'b0;
    rpm_scale     = RPM_CONST_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_long_overflow_run();
    test_rpm_constant_min();
    test_rpm_constant_max();
    test_zero_average();
    test_random_constants();
    test_steady_stream();

    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
    if (faults == 0) begin
      $display("PASS tachometer_period_average_rpm_core");
    end else begin
      $display("FAIL tachometer_period_average_rpm_core");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tach_pkg.sv
sv/tach_front.sv
sv/tach_queue.sv
sv/tach_back.sv
sv/tachometer_period_average_rpm_core.sv
sv/tach_checker.sv
dv/tachometer_period_average_rpm_core_tb.sv
